### src/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg: shared constants and types for the ToF phase atan2 pipeline
// Fixed-point format, rounded angle constants, reciprocal constants for
// the series divisions and the context word that rides along the pipeline.
// ----------------------------------------------------------------------------
package tpa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_W     = 32 + FRAC_BITS;   // dividend width of the dividers
	localparam int M_W       = FRAC_BITS + 1;    // series operand width, 0..1.0
	localparam int DIV_STEPS = 32;               // quotient bits per divide
	localparam int ANGLE_W   = 20;

	// reciprocals for the truncating divisions by 3 and 5
	localparam int RCP_K = FRAC_BITS + 2;
	localparam logic [RCP_K-1:0] RCP3 = RCP_K'((64'd1 << RCP_K) / 3);
	localparam logic [RCP_K-1:0] RCP5 = RCP_K'((64'd1 << RCP_K) / 5);

	localparam longint PI_Q32      = 64'sd13493037705;
	localparam longint HALF_PI_Q32 = 64'sd6746518852;
	localparam logic [31:0] PI_FX =
		32'((PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS));
	localparam logic [31:0] HALF_PI_FX =
		32'((HALF_PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS));
	localparam logic [31:0] ONE_FX = 32'd1 << FRAC_BITS;

	// per-item flags and magnitude carried beside the datapath
	typedef struct packed {
		logic        x_zero;
		logic        x_neg;
		logic        y_neg;
		logic        y_zero;
		logic        ovf;     // |y|/|x| overflows 32 quotient bits
		logic        fold;    // |z| > 1, use pi/2 - atan(1/|z|)
		logic        neg;     // z < 0
		logic [31:0] mag;     // saturated |z|
	} tpa_ctx_t;

endpackage

### src/tpa_div.sv
// ----------------------------------------------------------------------------
// tpa_div: pipelined restoring divider, one quotient bit per stage
// Divides num by den giving 32 quotient bits. The upper part of num above
// bit 31 must be below den; other cases give a don't-care quotient.
// ----------------------------------------------------------------------------
module tpa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [tpa_pkg::NUM_W-1:0]  num,
	input  logic [31:0]                den,
	input  tpa_pkg::tpa_ctx_t          in_ctx,
	output logic                       out_vld,
	output logic [31:0]                quo,
	output tpa_pkg::tpa_ctx_t          out_ctx
);

	localparam int N = tpa_pkg::DIV_STEPS;

	// index 0 is the stage input, 1..N are registers
	logic [31:0]       stg_rem [0:N];
	logic [31:0]       stg_nlo [0:N];
	logic [31:0]       stg_quo [0:N];
	logic [31:0]       stg_den [0:N];
	tpa_pkg::tpa_ctx_t stg_ctx [0:N];
	logic              stg_vld [0:N];

	logic [31:0] nxt_rem [0:N-1];
	logic        nxt_bit [0:N-1];

	always_comb begin
		stg_rem[0] = 32'(num[tpa_pkg::NUM_W-1:32]);
		stg_nlo[0] = num[31:0];
		stg_quo[0] = '0;
		stg_den[0] = den;
		stg_ctx[0] = in_ctx;
		stg_vld[0] = in_vld;
	end

	// one trial subtract per stage
	always_comb begin
		logic [32:0] t;
		logic [32:0] d;
		for (int i = 0; i < N; i++) begin
			t = {stg_rem[i], stg_nlo[i][31]};
			d = t - {1'b0, stg_den[i]};
			nxt_bit[i] = (t >= {1'b0, stg_den[i]});
			nxt_rem[i] = nxt_bit[i] ? d[31:0] : t[31:0];
		end
	end

	// stage registers
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				stg_rem[i+1] <= nxt_rem[i];
				stg_nlo[i+1] <= {stg_nlo[i][30:0], 1'b0};
				stg_quo[i+1] <= {stg_quo[i][30:0], nxt_bit[i]};
				stg_den[i+1] <= stg_den[i];
				stg_ctx[i+1] <= stg_ctx[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_vld[i+1] <= 1'b0;
			end else if (en) begin
				stg_vld[i+1] <= stg_vld[i];
			end
		end
	end

	assign out_vld = stg_vld[N];
	assign quo     = stg_quo[N];
	assign out_ctx = stg_ctx[N];

endmodule

### src/tpa_series.sv
// ----------------------------------------------------------------------------
// tpa_series: odd power series m - m^3/3 + m^5/5 for 0 <= m <= 1.0
// Five register stages; every product is registered before the next use.
// ----------------------------------------------------------------------------
module tpa_series (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  logic [tpa_pkg::M_W-1:0]  m,
	input  tpa_pkg::tpa_ctx_t        in_ctx,
	output logic                     out_vld,
	output logic [tpa_pkg::M_W-1:0]  res,
	output tpa_pkg::tpa_ctx_t        out_ctx
);

	localparam int F  = tpa_pkg::FRAC_BITS;
	localparam int W  = tpa_pkg::M_W;
	localparam int K  = tpa_pkg::RCP_K;
	localparam int PW = W + K;

	logic [W-1:0]  m_s1, m2_s1;
	logic [W-1:0]  m_s2, m2_s2, m3_s2;
	logic [W-1:0]  m_s3, m3_s3, m5_s3;
	logic [PW-1:0] p3_s3;
	logic [W-1:0]  m_s4, q3_s4, m5_s4;
	logic [PW-1:0] p5_s4;
	logic [W-1:0]  res_s5;
	tpa_pkg::tpa_ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [2*W-1:0] sq, cu, fi;
	logic [W-1:0]   q3_c, q5_c;
	logic [W+1:0]   r3, r5;
	logic [W:0]     sum;

	logic [PW-1:0] RCP3_W, RCP5_W;
	assign RCP3_W = PW'(tpa_pkg::RCP3);
	assign RCP5_W = PW'(tpa_pkg::RCP5);

	// truncated fixed-point products
	assign sq = m * m;
	assign cu = m2_s1 * m_s1;
	assign fi = m3_s2 * m2_s2;

	// divide by 3 and 5: reciprocal estimate, then one correction step
	always_comb begin
		q3_c = p3_s3[K +: W];
		r3   = (W+2)'(m3_s3) - (((W+2)'(q3_c) << 1) + (W+2)'(q3_c));
		if (r3 >= (W+2)'(3)) q3_c = q3_c + 1'b1;
		q5_c = p5_s4[K +: W];
		r5   = (W+2)'(m5_s4) - (((W+2)'(q5_c) << 2) + (W+2)'(q5_c));
		if (r5 >= (W+2)'(5)) q5_c = q5_c + 1'b1;
		sum  = (W+1)'(m_s4) - (W+1)'(q3_s4) + (W+1)'(q5_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= m;
			m2_s1  <= sq[F +: W];
			ctx_s1 <= in_ctx;
			m_s2   <= m_s1;
			m2_s2  <= m2_s1;
			m3_s2  <= cu[F +: W];
			ctx_s2 <= ctx_s1;
			m_s3   <= m_s2;
			m3_s3  <= m3_s2;
			m5_s3  <= fi[F +: W];
			p3_s3  <= m3_s2 * RCP3_W;
			ctx_s3 <= ctx_s2;
			m_s4   <= m_s3;
			q3_s4  <= q3_c;
			m5_s4  <= m5_s3;
			p5_s4  <= m5_s3 * RCP5_W;
			ctx_s4 <= ctx_s3;
			res_s5 <= sum[W-1:0];
			ctx_s5 <= ctx_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign out_vld = vld_s5;
	assign res     = res_s5;
	assign out_ctx = ctx_s5;

endmodule

### src/tof_phase_atan2.sv
// ----------------------------------------------------------------------------
// tof_phase_atan2: phase angle atan2(a3 - a1, a2 - a0) of one ToF pixel
// Stages: two 32-stage dividers, five series stages, four glue stages and
// one output stage lie between sample accept and angle valid.
// Throughput: one item per cycle; a held output stalls the whole pipeline.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
module tof_phase_atan2 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [31:0] sample_0,
	input  logic [31:0] sample_1,
	input  logic [31:0] sample_2,
	input  logic [31:0] sample_3,
	output logic        angle_valid,
	input  logic        angle_stall,
	output logic [19:0] angle
);

	localparam int F = tpa_pkg::FRAC_BITS;
	localparam int W = tpa_pkg::M_W;

	logic en;

	logic [31:0] y_s1, x_s1;
	logic        vld_s1;

	logic [tpa_pkg::NUM_W-1:0] num_s2;
	logic [31:0]               den_s2;
	tpa_pkg::tpa_ctx_t         ctx_s2;
	logic                      vld_s2;

	logic              d1_vld;
	logic [31:0]       d1_quo;
	tpa_pkg::tpa_ctx_t d1_ctx;

	tpa_pkg::tpa_ctx_t ctx_s3, ctx3_c;
	logic              vld_s3;

	logic              d2_vld;
	logic [31:0]       d2_quo;
	tpa_pkg::tpa_ctx_t d2_ctx;

	logic [W-1:0]      m_s4;
	tpa_pkg::tpa_ctx_t ctx_s4;
	logic              vld_s4;

	logic              sr_vld;
	logic [W-1:0]      sr_res;
	tpa_pkg::tpa_ctx_t sr_ctx;

	logic [19:0] angle_q;
	logic        angle_valid_q;

	// pipeline advances unless the output item is held
	assign en           = !(angle_valid_q && angle_stall);
	assign sample_stall = !en;

	// stage 1: phase differences, 32-bit wrap
	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= sample_3 - sample_1;
			x_s1 <= sample_2 - sample_0;
		end
	end

	// stage 2: magnitudes, signs and overflow check of |y|/|x|
	always_ff @(posedge clk) begin
		logic [31:0] ay, ax;
		logic [tpa_pkg::NUM_W-1:0] n;
		logic ov;
		tpa_pkg::tpa_ctx_t c;
		if (en) begin
			ay = y_s1[31] ? (32'd0 - y_s1) : y_s1;
			ax = x_s1[31] ? (32'd0 - x_s1) : x_s1;
			n  = {ay, F'(0)};
			ov = 64'(n) >= {ax, 32'd0};
			c        = '0;
			c.x_zero = (x_s1 == 32'd0);
			c.x_neg  = x_s1[31];
			c.y_neg  = y_s1[31];
			c.y_zero = (y_s1 == 32'd0);
			c.ovf    = ov;
			num_s2 <= ov ? '0 : n;
			den_s2 <= ax;
			ctx_s2 <= c;
		end
	end

	tpa_div u_div_ratio (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.num     (num_s2),
		.den     (den_s2),
		.in_ctx  (ctx_s2),
		.out_vld (d1_vld),
		.quo     (d1_quo),
		.out_ctx (d1_ctx)
	);

	// stage 3: saturate |z|, decide the fold to 1/|z|
	always_comb begin
		logic        sgn;
		logic [31:0] lim;
		ctx3_c     = d1_ctx;
		sgn        = d1_ctx.y_neg ^ d1_ctx.x_neg;
		lim        = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
		ctx3_c.mag = (d1_ctx.ovf || d1_quo > lim) ? lim : d1_quo;
		ctx3_c.neg = sgn && (ctx3_c.mag != 32'd0);
		ctx3_c.fold = ctx3_c.mag > tpa_pkg::ONE_FX;
	end

	always_ff @(posedge clk) begin
		if (en) ctx_s3 <= ctx3_c;
	end

	tpa_div u_div_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.num     (tpa_pkg::NUM_W'(1) << (2 * F)),
		.den     (ctx_s3.mag),
		.in_ctx  (ctx_s3),
		.out_vld (d2_vld),
		.quo     (d2_quo),
		.out_ctx (d2_ctx)
	);

	// stage 4: series operand
	always_ff @(posedge clk) begin
		if (en) begin
			m_s4   <= d2_ctx.fold ? d2_quo[W-1:0] : d2_ctx.mag[W-1:0];
			ctx_s4 <= d2_ctx;
		end
	end

	tpa_series u_series (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s4),
		.m       (m_s4),
		.in_ctx  (ctx_s4),
		.out_vld (sr_vld),
		.res     (sr_res),
		.out_ctx (sr_ctx)
	);

	// output stage: unfold, odd symmetry, quadrant correction
	always_ff @(posedge clk) begin
		logic [31:0] r, a, ang;
		if (en) begin
			r = sr_ctx.fold ? (tpa_pkg::HALF_PI_FX - 32'(sr_res)) : 32'(sr_res);
			a = sr_ctx.neg ? (32'd0 - r) : r;
			if (sr_ctx.x_zero) begin
				if (sr_ctx.y_zero) ang = 32'd0;
				else if (sr_ctx.y_neg) ang = 32'd0 - tpa_pkg::HALF_PI_FX;
				else ang = tpa_pkg::HALF_PI_FX;
			end else if (sr_ctx.x_neg) begin
				ang = sr_ctx.y_neg ? (a - tpa_pkg::PI_FX) : (a + tpa_pkg::PI_FX);
			end else begin
				ang = a;
			end
			angle_q <= ang[tpa_pkg::ANGLE_W-1:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			vld_s4        <= 1'b0;
			angle_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1        <= sample_valid;
			vld_s2        <= vld_s1;
			vld_s3        <= d1_vld;
			vld_s4        <= d2_vld;
			angle_valid_q <= sr_vld;
		end
	end

	assign angle_valid = angle_valid_q;
	assign angle       = angle_q;

endmodule

### src/tpa_check.sv
// ----------------------------------------------------------------------------
// tpa_check: port-level checks for tof_phase_atan2
// Watches the handshakes and the angle range on the top level's ports.
// ----------------------------------------------------------------------------
module tpa_check (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_stall,
	input logic        angle_valid,
	input logic        angle_stall,
	input logic [19:0] angle
);

	// a held output item keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid && angle_stall |=> angle_valid && $stable(angle))
		else $error("angle changed while stalled");

	// input only stalls behind a held output item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> angle_valid && angle_stall)
		else $error("input stalled without output backpressure");

	// angle stays within minus 4.0 to 4.0 (16 fraction bits), which holds minus pi to pi
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |-> ($signed(angle) >= -20'sd262144) && ($signed(angle) <= 20'sd262144))
		else $error("angle out of range");

	// no output item during reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !angle_valid)
		else $error("angle valid during reset");

endmodule

bind tof_phase_atan2 tpa_check u_tpa_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.angle_valid  (angle_valid),
	.angle_stall  (angle_stall),
	.angle        (angle)
);

### bench/tb_tof_phase_atan2.sv
// ----------------------------------------------------------------------------
// tb_tof_phase_atan2: self-checking bench for the ToF phase atan2 pipeline
// A directed table of corner pixels is followed by random pixels. Every
// accepted item is predicted from its table row or by a behavioral atan2
// model and compared in order with the angles that leave the block, under
// random gaps, output stalls and one long output hold that backs up the pipe.
// ----------------------------------------------------------------------------
module tb_tof_phase_atan2;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 650;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 120;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	logic [31:0] sample_0, sample_1, sample_2, sample_3;
	logic        angle_valid;
	logic        angle_stall;
	logic [19:0] angle;

	logic [19:0] angle_due[$];
	int          n_accepted;
	int          n_checked;
	int          n_errors;
	bit          row_typed;
	logic [19:0] row_angle;

	typedef struct {
		logic [31:0] s0, s1, s2, s3;
		bit          typed;
		logic [19:0] want;
	} pixel_row_t;

	tof_phase_atan2 dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.sample_0(sample_0), .sample_1(sample_1),
		.sample_2(sample_2), .sample_3(sample_3),
		.angle_valid(angle_valid), .angle_stall(angle_stall), .angle(angle)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// --- fixed-point atan2 predictor ---
	function automatic longint q_const(longint q32);
		return (q32 + (longint'(1) <<< (31 - tpa_pkg::FRAC_BITS)))
			>>> (32 - tpa_pkg::FRAC_BITS);
	endfunction

	function automatic longint ratio_sat(longint num, longint den);
		longint q;
		q = (num * (longint'(1) <<< tpa_pkg::FRAC_BITS)) / den;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q;
	endfunction

	function automatic longint poly_atan(longint m);
		longint m2, m3, m5;
		m2 = (m * m) >>> tpa_pkg::FRAC_BITS;
		m3 = (m2 * m) >>> tpa_pkg::FRAC_BITS;
		m5 = (m3 * m2) >>> tpa_pkg::FRAC_BITS;
		return m - m3 / 3 + m5 / 5;
	endfunction

	function automatic longint atan_fx(longint z);
		longint one, mag, r;
		one = longint'(1) <<< tpa_pkg::FRAC_BITS;
		mag = (z < 0) ? -z : z;
		if (mag == 0) return 0;
		if (mag <= one) r = poly_atan(mag);
		else r = q_const(64'sd6746518852) - poly_atan(ratio_sat(one, mag));
		return (z < 0) ? -r : r;
	endfunction

	function automatic logic [19:0] pixel_angle(logic [31:0] s0, s1, s2, s3);
		logic [31:0] dy, dx;
		longint y, x, a, pi_v, hp;
		dy = s3 - s1;
		dx = s2 - s0;
		y = longint'($signed(dy));
		x = longint'($signed(dx));
		pi_v = q_const(64'sd13493037705);
		hp = q_const(64'sd6746518852);
		if (x > 0) a = atan_fx(ratio_sat(y, x));
		else if (x < 0) begin
			a = atan_fx(ratio_sat(y, x));
			a = (y >= 0) ? a + pi_v : a - pi_v;
		end else if (y > 0) a = hp;
		else if (y < 0) a = -hp;
		else a = 0;
		return a[19:0];
	endfunction

	// --- accept side: record the expected angle of each accepted pixel ---
	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall) begin
			angle_due.push_back(row_typed ? row_angle
				: pixel_angle(sample_0, sample_1, sample_2, sample_3));
			n_accepted <= n_accepted + 1;
		end
	end

	// --- result side: compare against the oldest expectation ---
	always @(posedge clk) begin
		if (arst_n && angle_valid && !angle_stall) begin
			if (angle_due.size() == 0) begin
				$display("%0t: unexpected angle %h", $time, angle);
				n_errors++;
			end else begin
				logic [19:0] want;
				want = angle_due.pop_front();
				if (angle !== want) begin
					$display("%0t: angle mismatch expected %h actual %h", $time, want, angle);
					n_errors++;
				end
				n_checked++;
			end
		end
	end

	// --- output stall pattern with one long hold once the pipe is busy ---
	initial begin
		bit held;
		int mode;
		held = 0;
		mode = 0;
		angle_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && n_accepted >= 60) begin
				held = 1;
				angle_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
				case (mode)
					0: angle_stall <= 1'b0;
					1: angle_stall <= ($urandom_range(0, 3) == 0);
					default: angle_stall <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	// drive one pixel and hold it until it is taken
	task automatic send_pixel(logic [31:0] s0, s1, s2, s3);
		sample_valid <= 1'b1;
		sample_0 <= s0;
		sample_1 <= s1;
		sample_2 <= s2;
		sample_3 <= s3;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			sample_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] rand_sample(int kind);
		case (kind)
			0: return $urandom();
			1: return 32'($urandom_range(0, 4095)) - 32'd2048;
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($urandom_range(0, 1 << 20));
		endcase
	endfunction

	// --- stimulus ---
	initial begin
		pixel_row_t rows[$];
		logic [31:0] s0, s1, s2, s3;
		int burst, kind;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample_0 = '0; sample_1 = '0; sample_2 = '0; sample_3 = '0;
		n_accepted = 0; n_checked = 0; n_errors = 0;
		row_typed = 0; row_angle = '0;

		// corner pixels: zero x, signs of y, wrapping, saturated ratios
		rows = '{
			'{32'd0, 32'd0, 32'd0, 32'd0, 1, 20'h00000},
			'{32'd0, 32'd0, 32'd0, 32'd5, 1, 20'h19220},
			'{32'd0, 32'd5, 32'd0, 32'd0, 1, 20'he6de0},
			'{32'd0, 32'd7, 32'd9, 32'd7, 1, 20'h00000},
			'{32'd9, 32'd7, 32'd0, 32'd7, 1, 20'h3243f},
			'{32'd0, 32'd0, 32'd100, 32'd100, 0, '0},
			'{32'd100, 32'd0, 32'd0, 32'd100, 0, '0},
			'{32'd100, 32'd100, 32'd0, 32'd0, 0, '0},
			'{32'd0, 32'd100, 32'd100, 32'd0, 0, '0},
			'{32'd0, 32'd0, 32'd1, 32'h7fffffff, 0, '0},
			'{32'd0, 32'd0, 32'hffffffff, 32'h80000000, 0, '0},
			'{32'd0, 32'd0, 32'd1, 32'h80000000, 0, '0},
			'{32'd0, 32'd0, 32'hffffffff, 32'h7fffffff, 0, '0},
			'{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, '0},
			'{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, '0},
			'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 20'h00000},
			'{32'h80000000, 32'd0, 32'h80000000, 32'h7fffffff, 1, 20'h19220},
			'{32'd0, 32'd3, 32'd300000, 32'd300001, 0, '0},
			'{32'd0, 32'd0, 32'd65536, 32'd65537, 0, '0},
			'{32'd0, 32'd0, 32'hfffeffff, 32'd65537, 0, '0}
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			row_typed = rows[i].typed;
			row_angle = rows[i].want;
			send_pixel(rows[i].s0, rows[i].s1, rows[i].s2, rows[i].s3);
			idle_gap($urandom_range(0, 1));
		end
		row_typed = 0;

		// random pixels in bursts; one pause drains the pipe fully
		for (int n = 0; n < RANDOM_ITEMS; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
				kind = $urandom_range(0, 3);
				s0 = rand_sample(kind); s1 = rand_sample(kind);
				s2 = ($urandom_range(0, 15) == 0) ? s0 : rand_sample(kind);
				s3 = ($urandom_range(0, 15) == 0) ? s1 : rand_sample(kind);
				send_pixel(s0, s1, s2, s3);
			end
			if (n >= RANDOM_ITEMS / 2 && n - burst < RANDOM_ITEMS / 2) begin
				sample_valid <= 1'b0;
				while (angle_due.size() != 0) @(negedge clk);
			end else
				idle_gap($urandom_range(0, 8));
		end
		sample_valid <= 1'b0;

		while (angle_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Covered %0d pixels (corner table plus random bursts), %0d angles checked.",
			n_accepted, n_checked);
		if (n_errors == 0 && angle_due.size() == 0)
			$display("tb_tof_phase_atan2: clean");
		else
			$display("tb_tof_phase_atan2: errors");
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("%0t: timeout", $time);
		$display("tb_tof_phase_atan2: errors");
		$finish;
	end

endmodule

### tof_phase_atan2.f
src/tpa_pkg.sv
src/tpa_div.sv
src/tpa_series.sv
src/tof_phase_atan2.sv
src/tpa_check.sv
bench/tb_tof_phase_atan2.sv
